// File: src/hps_pkg.sv
// shared constants and codes for the h264 parameter set substitution block
package hps_pkg;

    localparam int SPS_BYTES = 128;
    localparam int PPS_BYTES = 64;
    localparam int OUT_LANES = 8;

    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 7;
    localparam int WORD_W  = 64;
    localparam int CNT_W   = 4;
    localparam int LEN_W   = 8;
    localparam int PLEN_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int LANE_W   = $clog2(OUT_LANES);
    localparam int SPS_ROWS = (SPS_BYTES + OUT_LANES - 1) / OUT_LANES;
    localparam int PPS_ROWS = (PPS_BYTES + OUT_LANES - 1) / OUT_LANES;
    localparam int TBL_ROWS = SPS_ROWS + PPS_ROWS;
    localparam int ROW_W    = $clog2(TBL_ROWS);

    localparam logic [ROW_W-1:0] SPS_BASE = '0;
    localparam logic [ROW_W-1:0] PPS_BASE = ROW_W'(SPS_ROWS);

    localparam logic [OP_W-1:0] OP_STREAM   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SPS = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_PPS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SPS_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PPS_LENGTH = 2'd1;

    localparam logic [BYTE_W-1:0] NAL_TYPE_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] NAL_SPS       = 8'd7;
    localparam logic [BYTE_W-1:0] NAL_PPS       = 8'd8;
    localparam logic [BYTE_W-1:0] START_LAST    = 8'd1;
    localparam int MIN_SPS_LEN = 4;

endpackage

// File: src/hps_in_if.sv
// input channel: stream bytes and table load words
interface hps_in_if;
    import hps_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] byte_value;
    logic [IDX_W-1:0]  table_index;
    logic              end_of_buffer;

    modport source(output valid, op, byte_value, table_index, end_of_buffer, input ready);
    modport sink(input valid, op, byte_value, table_index, end_of_buffer, output ready);
endinterface

// File: src/hps_out_if.sv
// output channel: packed result bytes
interface hps_out_if;
    import hps_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_bytes;
    logic [CNT_W-1:0]  byte_count;
    logic              buffer_done;
    logic              last;

    modport source(output valid, out_bytes, byte_count, buffer_done, last, input ready);
    modport sink(input valid, out_bytes, byte_count, buffer_done, last, output ready);
endinterface

// File: src/hps_cfg_if.sv
// configuration write channel
interface hps_cfg_if;
    import hps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: src/h264_parameter_set_substitution.sv
// H.264 Annex B parameter set substitution with row-organised table memory
//
// i_in carries one word per item: a stream byte (op 0) or a byte loaded into
// the SPS (op 1) or PPS (op 2) table. o_out carries up to eight bytes per
// word, first byte in the low lane, with last and buffer_done flags. i_cfg
// writes sps_length (index 0) and pps_length (index 1); it is always ready.
// Stream bytes have their word, if any, registered into o_out at the
// accepting edge, so a new byte is taken every cycle while the receiver
// keeps up and no table burst runs. A header byte of an SPS or PPS that
// is replaced starts a table burst: the tables sit in one memory of
// eight-byte rows read through a read-data register, one row is read
// per output word, and the block takes no input until the last row has
// been handed to o_out. Each row passes from the read-data register into
// the output register, one word a cycle while o_out is free.
// A stall on o_out holds the output word and drops i_in.ready until the
// word goes. Reset clears the parse state, both lengths and the output
// valid flag; table contents are undefined until loaded and need no clearing.
module h264_parameter_set_substitution (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hps_in_if.sink        i_in,
    hps_cfg_if.sink       i_cfg,
    hps_out_if.source     o_out
);
    import hps_pkg::*;

    typedef enum logic [1:0] {
        MODE_OUTSIDE,
        MODE_HEADER,
        MODE_COPY,
        MODE_DROP
    } t_mode;

    // table memory
    logic [WORD_W-1:0] r_tbl_mem [TBL_ROWS];
    logic [WORD_W-1:0] r_rd_data;

    // control state
    t_mode             r_mode;
    logic [1:0]        r_zeros;
    logic              r_busy;
    logic              r_rd_valid;
    logic [ROW_W-1:0]  r_row;
    logic [LEN_W-1:0]  r_bytes_left;
    logic              r_tbl_eob;
    logic [LEN_W-1:0]  r_sps_len;
    logic [PLEN_W-1:0] r_pps_len;

    // output register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_bytes;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_out_done;
    logic              r_out_last;

    logic              in_fire;
    logic              out_free;
    logic              stream_fire;
    logic [BYTE_W-1:0] b;
    logic              eob;
    logic [LEN_W:0]    sl_eff;
    logic [LEN_W:0]    pl_eff;
    logic              hdr;
    logic              take_sps;
    logic              take_tbl;
    t_mode             eff_mode;
    logic              start_code;
    logic [CNT_W-1:0]  emit_cnt;
    logic [WORD_W-1:0] stream_word;
    t_mode             n_mode;
    logic [1:0]        n_zeros;
    logic [LEN_W-1:0]  tbl_len;
    logic              tbl_step;
    logic              tbl_last;
    logic [CNT_W-1:0]  row_cnt;
    logic [WORD_W-1:0] row_word;
    logic              rd_en;
    logic [ROW_W-1:0]  n_row;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_row;
    logic [LANE_W-1:0] wr_lane;

    assign in_fire     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_busy && out_free;
    assign i_cfg.ready = 1'b1;
    assign stream_fire = in_fire && (i_in.op == OP_STREAM);

    assign o_out.valid       = r_out_valid;
    assign o_out.out_bytes   = r_out_bytes;
    assign o_out.byte_count  = r_out_count;
    assign o_out.buffer_done = r_out_done;
    assign o_out.last        = r_out_last;

    // held bytes are always a run of zeros, so a count stands for them
    always_comb begin
        b   = i_in.byte_value;
        eob = i_in.end_of_buffer;

        sl_eff = ((LEN_W+1)'(r_sps_len) > (LEN_W+1)'(SPS_BYTES)) ?
                 (LEN_W+1)'(SPS_BYTES) : (LEN_W+1)'(r_sps_len);
        pl_eff = ((LEN_W+1)'(r_pps_len) > (LEN_W+1)'(PPS_BYTES)) ?
                 (LEN_W+1)'(PPS_BYTES) : (LEN_W+1)'(r_pps_len);

        hdr      = (r_mode == MODE_HEADER);
        take_sps = hdr && (sl_eff >= (LEN_W+1)'(MIN_SPS_LEN))
                   && ((b & NAL_TYPE_MASK) == NAL_SPS);
        take_tbl = take_sps || (hdr && (sl_eff >= (LEN_W+1)'(MIN_SPS_LEN))
                   && ((b & NAL_TYPE_MASK) == NAL_PPS) && (pl_eff != '0));
        eff_mode = hdr ? (take_tbl ? MODE_DROP : MODE_COPY) : r_mode;
        tbl_len  = take_sps ? sl_eff[LEN_W-1:0] : pl_eff[LEN_W-1:0];

        start_code = (b == START_LAST) && (r_zeros >= 2'd2);

        if ((b == '0) && !eob) begin
            emit_cnt = (r_zeros == 2'd3) ? CNT_W'(1) : '0;
        end else begin
            emit_cnt = CNT_W'(r_zeros) + CNT_W'(1);
        end
        if ((eff_mode == MODE_DROP) && !start_code) begin
            emit_cnt = '0;
        end
        stream_word = WORD_W'(b) << {r_zeros, 3'b000};

        if (eob) begin
            n_zeros = '0;
        end else if (b == '0) begin
            n_zeros = (r_zeros == 2'd3) ? r_zeros : r_zeros + 2'd1;
        end else begin
            n_zeros = '0;
        end

        if (eob) begin
            n_mode = MODE_OUTSIDE;
        end else if (start_code) begin
            n_mode = MODE_HEADER;
        end else begin
            n_mode = eff_mode;
        end
    end

    // table burst: one row a cycle while the output register is free
    always_comb begin
        tbl_step = r_busy && r_rd_valid && out_free;
        tbl_last = (r_bytes_left <= LEN_W'(OUT_LANES));
        row_cnt  = tbl_last ? CNT_W'(r_bytes_left) : CNT_W'(OUT_LANES);
        for (int j = 0; j < OUT_LANES; j++) begin
            row_word[8*j +: 8] = (CNT_W'(j) < row_cnt) ? r_rd_data[8*j +: 8] : 8'h00;
        end
        rd_en = (stream_fire && take_tbl) || (tbl_step && !tbl_last);
        n_row = (stream_fire && take_tbl) ? (take_sps ? SPS_BASE : PPS_BASE)
                                          : r_row + ROW_W'(1);
    end

    // loads never meet a burst read of the same cycle, so no forwarding needed
    always_comb begin
        wr_lane = i_in.table_index[LANE_W-1:0];
        if (i_in.op == OP_LOAD_SPS) begin
            wr_row = SPS_BASE + ROW_W'(i_in.table_index >> LANE_W);
            wr_en  = in_fire && ((IDX_W+1)'(i_in.table_index) < (IDX_W+1)'(SPS_BYTES));
        end else begin
            wr_row = PPS_BASE + ROW_W'(i_in.table_index >> LANE_W);
            wr_en  = in_fire && (i_in.op == OP_LOAD_PPS)
                     && ((IDX_W+1)'(i_in.table_index) < (IDX_W+1)'(PPS_BYTES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tbl_mem[wr_row][8*wr_lane +: 8] <= b;
        end
        if (rd_en) begin
            r_rd_data <= r_tbl_mem[n_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OUTSIDE;
            r_zeros     <= '0;
            r_busy      <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sps_len   <= '0;
            r_pps_len   <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_SPS_LENGTH: r_sps_len <= i_cfg.data;
                    REG_PPS_LENGTH: r_pps_len <= i_cfg.data[PLEN_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (rd_en) begin
                r_row <= n_row;
            end

            if (stream_fire) begin
                r_mode  <= n_mode;
                r_zeros <= n_zeros;
                if (emit_cnt != '0) begin
                    r_out_valid <= 1'b1;
                    r_out_bytes <= stream_word;
                    r_out_count <= emit_cnt;
                    r_out_done  <= eob;
                    r_out_last  <= 1'b1;
                end
                if (take_tbl) begin
                    r_busy       <= 1'b1;
                    r_rd_valid   <= 1'b1;
                    r_bytes_left <= tbl_len;
                    r_tbl_eob    <= eob;
                end
            end

            if (tbl_step) begin
                r_out_valid  <= 1'b1;
                r_out_bytes  <= row_word;
                r_out_count  <= row_cnt;
                r_out_done   <= r_tbl_eob && tbl_last;
                r_out_last   <= tbl_last;
                r_bytes_left <= r_bytes_left - LEN_W'(OUT_LANES);
                if (tbl_last) begin
                    r_busy     <= 1'b0;
                    r_rd_valid <= 1'b0;
                end
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count != '0) && (r_out_count <= CNT_W'(OUT_LANES)))
        else $error("output word with bad byte count");

    a_read_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> r_busy)
        else $error("table read data pending outside a burst");

    a_burst_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_bytes_left != '0))
        else $error("table burst with nothing left to send");

    a_header_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HEADER) |-> (r_zeros == '0))
        else $error("zeros held while awaiting a header byte");

endmodule

// File: bench/h264_parameter_set_substitution_test.sv
`timescale 1ns / 1ps
// self-checking bench: predicts every output word of the parameter set substitution block
module h264_parameter_set_substitution_test;
    import hps_pkg::*;

    localparam logic [OP_W-1:0]      OP_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [4:0]           NAL_SLICE_IDR = 5'd5;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 10;
    localparam int DRAIN_GUARD  = 20000;

    typedef enum int {PM_OUTSIDE, PM_HEADER, PM_COPY, PM_DROP} t_parse_mode;

    typedef struct {
        logic [WORD_W-1:0] out_bytes;
        logic [CNT_W-1:0]  byte_count;
        logic              buffer_done;
        logic              last;
    } t_out_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hps_in_if  in_ch();
    hps_cfg_if cfg_ch();
    hps_out_if out_ch();

    h264_parameter_set_substitution uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // shadow of the block
    logic [BYTE_W-1:0] sps_copy [SPS_BYTES];
    logic [BYTE_W-1:0] pps_copy [PPS_BYTES];
    logic [BYTE_W-1:0] window [4];
    int unsigned       window_fill = 0;
    t_parse_mode       nal_mode = PM_OUTSIDE;
    int unsigned       sps_len_reg = 0;
    int unsigned       pps_len_reg = 0;
    logic [BYTE_W-1:0] emitted [$];
    t_out_word         expected_words [$];

    int mismatches  = 0;
    int sent_stream = 0;
    bit calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void shift_window(int unsigned n);
        if (n >= window_fill) begin
            window_fill = 0;
        end else begin
            for (int k = 0; k + n < window_fill; k++) window[k] = window[k + n];
            window_fill -= n;
        end
    endfunction

    // held bytes agree with a start code of plen bytes over their common length
    function automatic bit window_agrees(int unsigned plen);
        bit ok;
        ok = 1'b1;
        for (int k = 0; k < plen && k < window_fill; k++)
            if (window[k] != ((k == plen - 1) ? START_LAST : 8'h00)) ok = 1'b0;
        return ok;
    endfunction

    // 4 or 3 for a start code, 0 for none, -1 while undecided
    function automatic int start_code_at_front(bit closing);
        if (window_agrees(4)) begin
            if (window_fill >= 4) return 4;
            if (!closing) return -1;
        end
        if (window_agrees(3)) begin
            if (window_fill >= 3) return 3;
            if (!closing) return -1;
        end
        return 0;
    endfunction

    function automatic void take_header();
        int unsigned sl, pl;
        logic [BYTE_W-1:0] kind;
        sl = (sps_len_reg > SPS_BYTES) ? SPS_BYTES : sps_len_reg;
        pl = (pps_len_reg > PPS_BYTES) ? PPS_BYTES : pps_len_reg;
        kind = window[0] & NAL_TYPE_MASK;
        if (sl >= MIN_SPS_LEN && kind == NAL_SPS) begin
            for (int k = 0; k < sl; k++) emitted.push_back(sps_copy[k]);
            nal_mode = PM_DROP;
        end else if (sl >= MIN_SPS_LEN && kind == NAL_PPS && pl > 0) begin
            for (int k = 0; k < pl; k++) emitted.push_back(pps_copy[k]);
            nal_mode = PM_DROP;
        end else begin
            nal_mode = PM_COPY;
        end
    endfunction

    function automatic void scan_window(bit closing);
        int sc;
        bit stuck;
        stuck = 1'b0;
        while (window_fill > 0 && !stuck) begin
            if (nal_mode == PM_HEADER) begin
                // header byte stays in the window for the scan
                take_header();
            end else begin
                sc = start_code_at_front(closing);
                if (sc < 0) begin
                    stuck = 1'b1;
                end else if (sc > 0) begin
                    for (int k = 0; k < sc; k++) emitted.push_back(window[k]);
                    shift_window(sc);
                    nal_mode = PM_HEADER;
                end else begin
                    if (nal_mode != PM_DROP) emitted.push_back(window[0]);
                    shift_window(1);
                end
            end
        end
    endfunction

    function automatic void predict_stream_byte(logic [BYTE_W-1:0] val, logic eob);
        int n;
        t_out_word w;
        emitted.delete();
        if (window_fill >= 4) shift_window(1);
        window[window_fill] = val;
        window_fill++;
        scan_window(eob);
        if (eob) begin
            window_fill = 0;
            nal_mode = PM_OUTSIDE;
        end
        n = (emitted.size() + OUT_LANES - 1) / OUT_LANES;
        for (int k = 0; k < n; k++) begin
            w.out_bytes = '0;
            w.byte_count = '0;
            for (int j = 0; j < OUT_LANES && k * OUT_LANES + j < emitted.size(); j++) begin
                w.out_bytes[8 * j +: 8] = emitted[k * OUT_LANES + j];
                w.byte_count++;
            end
            w.last = (k == n - 1);
            w.buffer_done = w.last && eob;
            expected_words.push_back(w);
        end
    endfunction

    task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] val,
                             logic [IDX_W-1:0] idx, logic eob);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.byte_value <= val;
        in_ch.table_index <= idx;
        in_ch.end_of_buffer <= eob;
        do @(posedge i_clk); while (!in_ch.ready);
        case (op)
            OP_STREAM:   predict_stream_byte(val, eob);
            OP_LOAD_SPS: if (idx < SPS_BYTES) sps_copy[idx] = val;
            OP_LOAD_PPS: if (idx < PPS_BYTES) pps_copy[idx] = val;
            default: ;
        endcase
    endtask

    task automatic stream_byte(logic [BYTE_W-1:0] val, logic eob);
        send_item(OP_STREAM, val, IDX_W'($urandom), eob);
        sent_stream++;
    endtask

    // sender holds off until every predicted word has gone
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_SPS_LENGTH: sps_len_reg = val;
            REG_PPS_LENGTH: pps_len_reg = val[PLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_lengths(int unsigned sps, int unsigned pps);
        wait_idle();
        write_reg(REG_SPS_LENGTH, CFG_DATA_W'(sps));
        write_reg(REG_PPS_LENGTH, CFG_DATA_W'(pps));
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // lengths are zero after reset, so an sps must go through untouched
    task automatic test_passthrough_at_reset();
        logic [8:0] seq [] = '{9'h000, 9'h000, 9'h000, 9'h001, 9'h067, 9'h042,
                               9'h000, 9'h000, 9'h001, 9'h068, 9'h1CE};
        foreach (seq[i]) stream_byte(seq[i][7:0], seq[i][8]);
    endtask

    task automatic test_table_loads();
        for (int i = 0; i < SPS_BYTES; i++)
            send_item(OP_LOAD_SPS, BYTE_W'($urandom), IDX_W'(i), 1'($urandom));
        // entries past the pps table are ignored
        for (int i = 0; i < PPS_BYTES + 4; i++)
            send_item(OP_LOAD_PPS, BYTE_W'($urandom), IDX_W'(i), 1'($urandom));
        repeat (3) send_item(OP_SPARE, BYTE_W'($urandom), IDX_W'($urandom), 1'($urandom));
    endtask

    task automatic test_directed_substitution();
        logic [8:0] seq [] = '{
            9'h000, 9'h000, 9'h000, 9'h001, 9'h067, 9'h011,   // sps, four byte start code
            9'h000, 9'h000, 9'h001, 9'h0E8, 9'h033,           // pps, three byte start code
            9'h000, 9'h000, 9'h000, 9'h001, 9'h065, 9'h0FF,   // copied slice
            9'h000, 9'h000, 9'h101,                           // start code closing the buffer
            9'h000, 9'h000, 9'h000, 9'h001, 9'h007, 9'h044,
            9'h000, 9'h100                                    // held zeros dropped at buffer end
        };
        set_lengths(MIN_SPS_LEN, 1);
        foreach (seq[i]) stream_byte(seq[i][7:0], seq[i][8]);
    endtask

    task automatic random_nal();
        logic [4:0] kind;
        int payload;
        bit eob;
        case ($urandom_range(0, 4))
            0, 1: kind = NAL_SPS[4:0];
            2:    kind = NAL_PPS[4:0];
            3:    kind = NAL_SLICE_IDR;
            default: kind = 5'($urandom);
        endcase
        payload = $urandom_range(0, 5);
        eob = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1)) stream_byte(8'h00, 1'b0);
        stream_byte(8'h00, 1'b0);
        stream_byte(8'h00, 1'b0);
        stream_byte(START_LAST, 1'b0);
        stream_byte({3'($urandom), kind}, eob && payload == 0);
        for (int i = 0; i < payload; i++)
            stream_byte(($urandom_range(0, 7) == 0) ? 8'h00 : BYTE_W'($urandom_range(1, 255)),
                        eob && i == payload - 1);
    endtask

    task automatic random_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            stream_byte(($urandom_range(0, 2) == 0) ? BYTE_W'($urandom)
                                                     : BYTE_W'($urandom_range(0, 1)),
                        $urandom_range(0, 5) == 0);
    endtask

    task automatic random_phase(int unsigned sps, int unsigned pps);
        int goal;
        set_lengths(sps, pps);
        goal = sent_stream + PHASE_ITEMS;
        while (sent_stream < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: random_nal();
                7: random_noise();
                8: send_item($urandom_range(0, 1) ? OP_LOAD_SPS : OP_LOAD_PPS,
                             BYTE_W'($urandom), IDX_W'($urandom), 1'($urandom));
                default: begin
                    if ($urandom_range(0, 1)) begin
                        send_item(OP_SPARE, BYTE_W'($urandom), IDX_W'($urandom), 1'($urandom));
                    end else begin
                        // broken start code cut by the buffer end
                        stream_byte(8'h00, 1'b0);
                        stream_byte(8'h00, 1'b1);
                    end
                end
            endcase
            if (!calm && $urandom_range(0, 30) == 0) wait_idle();
        end
    endtask

    task automatic test_random_settings();
        random_phase(SPS_BYTES, PPS_BYTES);
        random_phase(255, 127);
        random_phase(MIN_SPS_LEN - 1, PPS_BYTES);
        random_phase(MIN_SPS_LEN, 0);
        random_phase($urandom_range(MIN_SPS_LEN, 24), $urandom_range(1, 20));
        calm = 1'b1;
        random_phase($urandom_range(MIN_SPS_LEN, SPS_BYTES), $urandom_range(0, PPS_BYTES));
    endtask

    // receiver stalls in bursts with quiet stretches between them
    initial begin
        out_ch.ready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(0, 40)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: got bytes %h count %0d done %b last %b",
                             out_ch.out_bytes, out_ch.byte_count, out_ch.buffer_done,
                             out_ch.last);
            end else begin
                want = expected_words.pop_front();
                if (want.out_bytes !== out_ch.out_bytes || want.byte_count !== out_ch.byte_count
                    || want.buffer_done !== out_ch.buffer_done || want.last !== out_ch.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("word mismatch: expected %h %0d %b %b, got %h %0d %b %b",
                                 want.out_bytes, want.byte_count, want.buffer_done, want.last,
                                 out_ch.out_bytes, out_ch.byte_count, out_ch.buffer_done,
                                 out_ch.last);
                end
            end
        end
    end

    initial begin
        int guard;
        in_ch.valid = 1'b0;
        in_ch.op = OP_STREAM;
        in_ch.byte_value = '0;
        in_ch.table_index = '0;
        in_ch.end_of_buffer = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_SPS_LENGTH;
        cfg_ch.data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_passthrough_at_reset();
        test_table_loads();
        test_directed_substitution();
        test_random_settings();

        in_ch.valid <= 1'b0;
        guard = 0;
        while (expected_words.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        mismatches += expected_words.size();

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
src/hps_pkg.sv
src/hps_in_if.sv
src/hps_out_if.sv
src/hps_cfg_if.sv
src/h264_parameter_set_substitution.sv
bench/h264_parameter_set_substitution_test.sv
